// ===== rtl/dmmd_pkg.sv =====
// Shared constants and types of the dynamic max Manhattan distance block.
`default_nettype none

package dmmd_pkg;

    // Table size and tree geometry
    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int TREE_LVLS  = IDX_W + 1;
    localparam int CNT_W      = IDX_W + 1;

    // Field widths
    localparam int OP_W    = 2;
    localparam int PIDX_W  = 10;
    localparam int COORD_W = 32;
    localparam int DIST_W  = 33;
    localparam int ACT_W   = 11;
    localparam int SD_W    = COORD_W + 2;

    localparam logic [ACT_W-1:0] ACT_RESET = 11'd1024;

    // Operation codes
    localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_X = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_Y = 2'd2;

    // Min/max of the rotated coordinates over one subtree
    typedef struct packed {
        logic signed [SD_W-1:0] smin;
        logic signed [SD_W-1:0] smax;
        logic signed [SD_W-1:0] dmin;
        logic signed [SD_W-1:0] dmax;
    } t_node;

    // Token handed from one tree level to the next
    typedef struct packed {
        logic  valid;
        logic  nonempty;
        t_node node;
    } t_tok;

    // Per-level control from the sequencer
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic [IDX_W-1:0] wr_addr;
        logic             merge_en;
        logic             upd;
        logic             clear;
    } t_cell_ctl;

    // Node memory request from a cell
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] wr_addr;
        t_node            wdata;
        logic             re;
        logic [IDX_W-1:0] rd_addr;
    } t_ram_req;

endpackage

`default_nettype wire

// ===== rtl/dmmd_item_if.sv =====
// Input item channel: operation, point index and coordinate.
`default_nettype none

interface dmmd_item_if;
    logic                                valid;
    logic                                ready;
    logic [dmmd_pkg::OP_W-1:0]           operation;
    logic [dmmd_pkg::PIDX_W-1:0]         point_index;
    logic signed [dmmd_pkg::COORD_W-1:0] coord_value;

    modport source(output valid, output operation, output point_index,
                   output coord_value, input ready);
    modport sink(input valid, input operation, input point_index,
                 input coord_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/dmmd_result_if.sv =====
// Result channel: greatest Manhattan distance.
`default_nettype none

interface dmmd_result_if;
    logic                        valid;
    logic                        ready;
    logic [dmmd_pkg::DIST_W-1:0] max_distance;

    modport source(output valid, output max_distance, input ready);
    modport sink(input valid, input max_distance, output ready);
endinterface

`default_nettype wire

// ===== rtl/dmmd_cfg_if.sv =====
// Configuration write channel: active point count.
`default_nettype none

interface dmmd_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [dmmd_pkg::ACT_W-1:0] active_points;

    modport source(output valid, output active_points, input ready);
    modport sink(input valid, input active_points, output ready);
endinterface

`default_nettype wire

// ===== rtl/dmmd_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module dmmd_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [2**AW];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wdata;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/dmmd_cell.sv =====
// One tree level: writes its node on an update, merges with the read node.
`default_nettype none

module dmmd_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire dmmd_pkg::t_cell_ctl i_ctl,
    input  wire dmmd_pkg::t_tok      i_tok,
    input  wire dmmd_pkg::t_node     i_rdata,
    output dmmd_pkg::t_tok           o_tok,
    output dmmd_pkg::t_ram_req       o_ram
);

    dmmd_pkg::t_node w_merged;
    dmmd_pkg::t_node n_node;
    logic            n_nonempty;
    dmmd_pkg::t_tok  r_tok;

    // Merge incoming node with the node read from this level
    always_comb begin
        w_merged.smin = (i_rdata.smin < i_tok.node.smin) ? i_rdata.smin : i_tok.node.smin;
        w_merged.smax = (i_rdata.smax > i_tok.node.smax) ? i_rdata.smax : i_tok.node.smax;
        w_merged.dmin = (i_rdata.dmin < i_tok.node.dmin) ? i_rdata.dmin : i_tok.node.dmin;
        w_merged.dmax = (i_rdata.dmax > i_tok.node.dmax) ? i_rdata.dmax : i_tok.node.dmax;
    end

    // Pick the node to hand on: an empty accumulator takes the read node as is
    always_comb begin
        if (!i_ctl.merge_en) begin
            n_node = i_tok.node;
        end else if (!i_tok.nonempty) begin
            n_node = i_rdata;
        end else begin
            n_node = w_merged;
        end
        n_nonempty = i_tok.nonempty | i_ctl.merge_en;
    end

    // Memory request: sweep zeros while clearing, store the new node on an update
    always_comb begin
        o_ram.we      = i_ctl.clear | (i_tok.valid & i_ctl.upd);
        o_ram.wr_addr = i_ctl.wr_addr;
        o_ram.wdata   = i_ctl.clear ? '0 : i_tok.node;
        o_ram.re      = i_ctl.rd_en;
        o_ram.rd_addr = i_ctl.rd_addr;
    end

    // Advance the token to the next level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
            if (i_tok.valid) begin
                r_tok.nonempty <= n_nonempty;
                r_tok.node     <= n_node;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ===== rtl/dynamic_max_manhattan_distance.sv =====
// Top level: point table with a min/max tree over rotated coordinates.
//
//   channel   | dir | payload                                   | transfer when
//   ----------+-----+-------------------------------------------+--------------
//   i_item    | in  | operation, point_index, coord_value       | valid & ready
//   o_result  | out | max_distance                              | valid & ready
//   i_cfg     | in  | active_points                             | valid & ready
//
// An update goes through the leaf stage and then one step per tree level in
// the row of level cells. A query takes the same walk plus the range stage.
// An update that is dropped (index out of range, unused code) is taken in the
// idle state and never enters the walk.
// After reset a clearing pass writes zeros to every memory, with i_item.ready
// low. A query result waits in the output register
// and the next item is taken meanwhile; a second query holds in its range
// stage until the output register is free. i_cfg is always ready.
`default_nettype none

module dynamic_max_manhattan_distance (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    dmmd_item_if.sink    i_item,
    dmmd_result_if.source o_result,
    dmmd_cfg_if.sink     i_cfg
);

    localparam int STEP_W = $clog2(dmmd_pkg::TREE_LVLS);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_LEAF  = 5'b00100,
        ST_WALK  = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state                              r_state, n_state;
    logic [dmmd_pkg::IDX_W-1:0]          r_clr, n_clr;
    logic [STEP_W-1:0]                   r_step, n_step;
    logic [dmmd_pkg::ACT_W-1:0]          r_act;
    logic                                r_qry;
    logic                                r_setx;
    logic [dmmd_pkg::IDX_W-1:0]          r_idx;
    logic [dmmd_pkg::COORD_W-1:0]        r_val;
    dmmd_pkg::t_tok                      r_leaf_tok;
    logic                                r_o_valid;
    logic [dmmd_pkg::DIST_W-1:0]         r_o_dist;

    logic [dmmd_pkg::CNT_W-1:0]          w_cnt;
    logic                                w_acc;
    logic                                w_in_qry;
    logic                                w_in_upd;
    logic                                w_acc_tree;
    logic [dmmd_pkg::IDX_W-1:0]          w_in_idx;
    logic                                w_clearing;
    logic                                w_load;
    logic [dmmd_pkg::COORD_W-1:0]        w_x_rdata, w_y_rdata;
    logic [dmmd_pkg::COORD_W-1:0]        w_xn, w_yn;
    logic signed [dmmd_pkg::SD_W-1:0]    w_s, w_d;
    logic signed [dmmd_pkg::SD_W-1:0]    w_rs, w_rd;
    logic [dmmd_pkg::DIST_W-1:0]         w_dist;
    dmmd_pkg::t_tok                      w_tok [dmmd_pkg::TREE_LVLS+1];

    // Effective count, capped at the table size
    assign w_cnt = (32'(r_act) >= 32'(dmmd_pkg::MAX_POINTS))
                 ? dmmd_pkg::CNT_W'(dmmd_pkg::MAX_POINTS)
                 : dmmd_pkg::CNT_W'(r_act);

    // Input decode
    assign i_item.ready = (r_state == ST_IDLE);
    assign w_acc        = i_item.valid & i_item.ready;
    assign w_in_idx     = dmmd_pkg::IDX_W'(i_item.point_index);
    assign w_clearing   = (r_state == ST_CLEAR);

    always_comb begin
        w_in_qry = 1'b0;
        w_in_upd = 1'b0;
        unique case (i_item.operation) inside
            dmmd_pkg::OP_QUERY: w_in_qry = 1'b1;
            dmmd_pkg::OP_SET_X,
            dmmd_pkg::OP_SET_Y: w_in_upd = (32'(i_item.point_index) < 32'(w_cnt));
            default:            w_in_upd = 1'b0;
        endcase
    end

    assign w_acc_tree = w_acc & (w_in_qry | w_in_upd);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_step  = r_step;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_acc_tree) begin
                    n_state = ST_LEAF;
                end
            end
            ST_LEAF: begin
                n_state = ST_WALK;
                n_step  = '0;
            end
            ST_WALK: begin
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(dmmd_pkg::IDX_W)) begin
                    n_state = r_qry ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_step  <= n_step;
        end
    end

    // Configuration register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= dmmd_pkg::ACT_RESET;
        end else if (i_cfg.valid) begin
            r_act <= i_cfg.active_points;
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_qry  <= w_in_qry;
            r_setx <= (i_item.operation == dmmd_pkg::OP_SET_X);
            r_idx  <= w_in_idx;
            r_val  <= i_item.coord_value;
        end
    end

    // Coordinate stores
    dmmd_ram #(
        .WIDTH (dmmd_pkg::COORD_W),
        .DEPTH (2**dmmd_pkg::IDX_W)
    ) u_x_store (
        .i_clk     (i_clk),
        .i_we      (w_clearing | ((r_state == ST_LEAF) & ~r_qry & r_setx)),
        .i_wr_addr (w_clearing ? r_clr : r_idx),
        .i_wdata   (w_clearing ? '0 : r_val),
        .i_re      (w_acc_tree),
        .i_rd_addr (w_in_idx),
        .o_rdata   (w_x_rdata)
    );

    dmmd_ram #(
        .WIDTH (dmmd_pkg::COORD_W),
        .DEPTH (2**dmmd_pkg::IDX_W)
    ) u_y_store (
        .i_clk     (i_clk),
        .i_we      (w_clearing | ((r_state == ST_LEAF) & ~r_qry & ~r_setx)),
        .i_wr_addr (w_clearing ? r_clr : r_idx),
        .i_wdata   (w_clearing ? '0 : r_val),
        .i_re      (w_acc_tree),
        .i_rd_addr (w_in_idx),
        .o_rdata   (w_y_rdata)
    );

    // Leaf: rebuild the point and rotate it
    assign w_xn = r_setx ? r_val : w_x_rdata;
    assign w_yn = r_setx ? w_y_rdata : r_val;
    assign w_s  = dmmd_pkg::SD_W'($signed(w_xn)) + dmmd_pkg::SD_W'($signed(w_yn));
    assign w_d  = dmmd_pkg::SD_W'($signed(w_xn)) - dmmd_pkg::SD_W'($signed(w_yn));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_tok.valid <= 1'b0;
        end else begin
            r_leaf_tok.valid <= (r_state == ST_LEAF);
            if (r_state == ST_LEAF) begin
                r_leaf_tok.nonempty  <= ~r_qry;
                r_leaf_tok.node.smin <= w_s;
                r_leaf_tok.node.smax <= w_s;
                r_leaf_tok.node.dmin <= w_d;
                r_leaf_tok.node.dmax <= w_d;
            end
        end
    end

    assign w_tok[0] = r_leaf_tok;

    // Row of level cells, leaves first, root last
    for (genvar k = 0; k < dmmd_pkg::TREE_LVLS; k++) begin : g_lvl
        localparam int LAW = (dmmd_pkg::IDX_W - k > 0) ? (dmmd_pkg::IDX_W - k) : 1;

        dmmd_pkg::t_cell_ctl w_ctl;
        dmmd_pkg::t_ram_req  w_req;
        dmmd_pkg::t_node     w_rdata;

        // Query reads the prefix node of this level, update reads the sibling
        always_comb begin
            w_ctl.rd_en    = w_acc_tree;
            w_ctl.rd_addr  = w_in_qry
                           ? dmmd_pkg::IDX_W'((w_cnt >> (k + 1)) << 1)
                           : dmmd_pkg::IDX_W'((w_in_idx >> k) ^ 1);
            w_ctl.wr_addr  = w_clearing ? r_clr : dmmd_pkg::IDX_W'(r_idx >> k);
            w_ctl.merge_en = r_qry ? w_cnt[k] : 1'b1;
            w_ctl.upd      = ~r_qry;
            w_ctl.clear    = w_clearing;
        end

        dmmd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_tok   (w_tok[k]),
            .i_rdata (w_rdata),
            .o_tok   (w_tok[k+1]),
            .o_ram   (w_req)
        );

        dmmd_ram #(
            .WIDTH ($bits(dmmd_pkg::t_node)),
            .DEPTH (2**(dmmd_pkg::IDX_W - k))
        ) u_node_ram (
            .i_clk     (i_clk),
            .i_we      (w_req.we),
            .i_wr_addr (w_req.wr_addr[LAW-1:0]),
            .i_wdata   (w_req.wdata),
            .i_re      (w_req.re),
            .i_rd_addr (w_req.rd_addr[LAW-1:0]),
            .o_rdata   (w_rdata)
        );
    end

    // Range stage on the root accumulator
    always_comb begin
        w_rs   = w_tok[dmmd_pkg::TREE_LVLS].node.smax - w_tok[dmmd_pkg::TREE_LVLS].node.smin;
        w_rd   = w_tok[dmmd_pkg::TREE_LVLS].node.dmax - w_tok[dmmd_pkg::TREE_LVLS].node.dmin;
        w_dist = '0;
        if (w_tok[dmmd_pkg::TREE_LVLS].nonempty) begin
            w_dist = (w_rs > w_rd) ? w_rs[dmmd_pkg::DIST_W-1:0] : w_rd[dmmd_pkg::DIST_W-1:0];
        end
    end

    // Output register
    assign w_load = (r_state == ST_DONE) & (~r_o_valid | o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_dist <= w_dist;
        end
    end

    assign o_result.valid        = r_o_valid;
    assign o_result.max_distance = r_o_dist;

endmodule

`default_nettype wire

// ===== rtl/dmmd_checker.sv =====
// Port-level checks of the max Manhattan distance block, bound to the top.
`default_nettype none

module dmmd_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_item_valid,
    input wire logic                        i_item_ready,
    input wire logic [dmmd_pkg::OP_W-1:0]   i_item_operation,
    input wire logic                        i_res_valid,
    input wire logic                        i_res_ready,
    input wire logic [dmmd_pkg::DIST_W-1:0] i_res_dist
);

    // A stalled result keeps its value
    a_res_hold: assert property (@(posedge i_clk)
        i_rst_n && i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_dist))
        else $error("result changed while stalled");

    // A query transfer blocks the input for its walk
    a_query_busy: assert property (@(posedge i_clk)
        i_rst_n && i_item_valid && i_item_ready && i_item_operation == dmmd_pkg::OP_QUERY
        |=> !i_item_ready)
        else $error("input ready right after a query transfer");

    // Reset starts the clearing pass with nothing to deliver
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_item_ready && !i_res_valid)
        else $error("ready or result valid right after reset");

    // No distance reaches the all-ones code
    a_dist_bound: assert property (@(posedge i_clk)
        i_rst_n && i_res_valid |-> i_res_dist != '1)
        else $error("distance out of range");

endmodule

bind dynamic_max_manhattan_distance dmmd_checker u_dmmd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_item_valid     (i_item.valid),
    .i_item_ready     (i_item.ready),
    .i_item_operation (i_item.operation),
    .i_res_valid      (o_result.valid),
    .i_res_ready      (o_result.ready),
    .i_res_dist       (o_result.max_distance)
);

`default_nettype wire
